[rtl/assert_macros.svh]
// Assertion macros used by the core's top-level file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/msc_pkg.sv]
// Package for the MIPS32 subset core: sizes, opcodes, controller states, commands.
// No dependencies.
`timescale 1ns / 1ps
package msc_pkg;
    localparam int MEM_BYTES = 4096;
    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [5:0] OP_RTYPE = 6'h00, OP_J = 6'h02, OP_JAL = 6'h03,
        OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_ADDI = 6'h08, OP_SLTI = 6'h0A,
        OP_SLTIU = 6'h0B, OP_ANDI = 6'h0C, OP_ORI = 6'h0D, OP_XORI = 6'h0E,
        OP_LW = 6'h23, OP_LBU = 6'h24, OP_LHU = 6'h25, OP_SB = 6'h28,
        OP_SH = 6'h29, OP_SW = 6'h2B;
    localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_JR = 6'h08,
        FN_ADD = 6'h20, FN_SUB = 6'h22, FN_AND = 6'h24, FN_OR = 6'h25,
        FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MEM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr_byte;   // write input byte to memory
        logic exec;      // decode and execute fetched word
        logic mem;       // finish load or store with memory word
        logic out_take;  // result taken downstream
    } t_cmd;

    typedef struct packed {
        logic needs_mem; // decoded instruction is load or store
    } t_stat;

    typedef struct packed {
        logic [AW-1:0] next_pc;
        logic          reg_written;
        logic [4:0]    reg_index;
        logic [31:0]   reg_value;
        logic [2:0]    store_bytes;
        logic [AW-1:0] store_addr;
    } t_result;
endpackage

[rtl/msc_if.sv]
// Valid/ready channel interfaces for the core's input and result items.
// Depends on msc_pkg.
`timescale 1ns / 1ps
interface msc_in_if import msc_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          req_type;
    logic [11:0]   mem_addr;
    logic [7:0]    mem_byte;
    modport source (output valid, req_type, mem_addr, mem_byte, input ready);
    modport sink (input valid, req_type, mem_addr, mem_byte, output ready);
endinterface

interface msc_out_if import msc_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [11:0]   next_pc;
    logic          reg_written;
    logic [4:0]    reg_index;
    logic [31:0]   reg_value;
    logic [2:0]    store_bytes;
    logic [11:0]   store_addr;
    modport source (output valid, next_pc, reg_written, reg_index, reg_value,
        store_bytes, store_addr, input ready);
    modport sink (input valid, next_pc, reg_written, reg_index, reg_value,
        store_bytes, store_addr, output ready);
endinterface

[rtl/mips32_subset_single_cycle_core.sv]
// Top level of the MIPS32 subset core: joins controller and datapath to the channels.
// Depends on msc_pkg, msc_if, msc_ctrl, msc_dp and assert_macros.svh.
//
// channel   dir  payload
// in        in   req_type, mem_addr, mem_byte
// out       out  next_pc, reg_written, reg_index, reg_value, store_bytes, store_addr
//
// A memory write item is accepted and then its result shows; an ALU, branch or jump
// item goes through fetch and execute, and a load or store through fetch, execute and
// data access, before its result shows. The registered read of the byte-lane memory sets this.
// Reset clears pc and registers; memory contents are kept. A stalled result holds
// and no new item is taken until it leaves.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mips32_subset_single_cycle_core import msc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    msc_in_if.sink    in_ch,
    msc_out_if.source out_ch
);
    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    in_take;

    assign in_take = in_ch.valid && in_ch.ready;

    msc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_type   (in_ch.req_type),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    msc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_take  (in_take),
        .i_mem_addr (in_ch.mem_addr),
        .i_mem_byte (in_ch.mem_byte),
        .o_stat     (stat),
        .o_res      (res)
    );

    assign out_ch.next_pc     = res.next_pc;
    assign out_ch.reg_written = res.reg_written;
    assign out_ch.reg_index   = res.reg_index;
    assign out_ch.reg_value   = res.reg_value;
    assign out_ch.store_bytes = res.store_bytes;
    assign out_ch.store_addr  = res.store_addr;

    `ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, out_ch.valid, !in_ch.ready)
    `ASSERT_IMP(a_r0_never, i_clk, i_rst_n, out_ch.valid && out_ch.reg_written,
        out_ch.reg_index != 5'd0)
    `ASSERT_NXT(a_exec_follows, i_clk, i_rst_n, in_take && in_ch.req_type,
        !out_ch.valid && !in_ch.ready)
endmodule

[rtl/msc_ctrl.sv]
// Controller state machine of the core: sequences fetch, execute, memory, output.
// Depends on msc_pkg.
`timescale 1ns / 1ps
module msc_ctrl import msc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_type,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = i_in_type ? S_EXEC : S_OUT;
            end
            S_EXEC: n_state = i_stat.needs_mem ? S_MEM : S_OUT;
            S_MEM:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.wr_byte = i_in_valid && !i_in_type;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_MEM:  o_cmd.mem = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.out_take = i_out_ready;
            end
            default: ;
        endcase
    end
endmodule

[rtl/msc_dp.sv]
// Datapath of the core: pc, register file, word-wide byte memory, ALU, result.
// Depends on msc_pkg.
`timescale 1ns / 1ps
module msc_dp import msc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic          i_in_take,
    input  logic [11:0]   i_mem_addr,
    input  logic [7:0]    i_mem_byte,
    output t_stat         o_stat,
    output t_result       o_res
);
    localparam int WA = AW - 2;
    localparam int NW = MEM_BYTES / 4;

    // memory as four byte lanes, word-interleaved
    logic [7:0] r_mem0 [NW];
    logic [7:0] r_mem1 [NW];
    logic [7:0] r_mem2 [NW];
    logic [7:0] r_mem3 [NW];
    logic [7:0] r_rd [4];

    logic [AW-1:0] r_pc;
    logic [31:0]   r_rf [32];
    t_result       r_res;
    logic [31:0]   r_b;
    logic [AW-1:0] r_ea;
    logic [5:0]    r_op;
    logic [4:0]    r_rt;
    logic [31:0]   ea32;

    // fetch/read addressing: byte k of word at base; data address while executing
    logic [AW-1:0] rd_base;
    logic [AW-1:0] byte_addr [4];
    logic [WA-1:0] lane_waddr [4];

    always_comb begin
        rd_base = (i_cmd.exec) ? ea32[AW-1:0] : r_pc;
        for (int k = 0; k < 4; k++) begin
            byte_addr[k] = rd_base + AW'(k);
        end
        for (int l = 0; l < 4; l++) begin
            lane_waddr[l] = '0;
            for (int k = 0; k < 4; k++) begin
                if (byte_addr[k][1:0] == 2'(l)) lane_waddr[l] = byte_addr[k][AW-1:2];
            end
        end
    end

    // registered memory read per lane, indexed by byte order k
    logic [7:0] r_lane [4];
    logic [1:0] r_rot;
    always_ff @(posedge i_clk) begin
        r_lane[0] <= r_mem0[lane_waddr[0]];
        r_lane[1] <= r_mem1[lane_waddr[1]];
        r_lane[2] <= r_mem2[lane_waddr[2]];
        r_lane[3] <= r_mem3[lane_waddr[3]];
        r_rot <= rd_base[1:0];
    end
    always_comb begin
        for (int k = 0; k < 4; k++) r_rd[k] = r_lane[2'(k) + r_rot];
    end
    logic [31:0] rd_word;
    assign rd_word = {r_rd[3], r_rd[2], r_rd[1], r_rd[0]};

    // decode
    logic [5:0] op, funct;
    logic [4:0] rs, rt, rd, shamt;
    logic [31:0] simm, zimm, a, b, pc4;
    assign op = rd_word[31:26];
    assign rs = rd_word[25:21];
    assign rt = rd_word[20:16];
    assign rd = rd_word[15:11];
    assign shamt = rd_word[10:6];
    assign funct = rd_word[5:0];
    assign zimm = {16'd0, rd_word[15:0]};
    assign simm = {{16{rd_word[15]}}, rd_word[15:0]};
    assign a = r_rf[rs];
    assign b = r_rf[rt];
    assign pc4 = 32'(r_pc) + 32'd4;

    logic [4:0]    dest;
    logic [31:0]   wval;
    logic [AW-1:0] newpc;
    logic [2:0]    sbytes;
    logic          is_mem;
    always_comb begin
        dest = '0; wval = '0; sbytes = '0; is_mem = 1'b0;
        newpc = pc4[AW-1:0];
        ea32 = a + simm;
        case (op)
            OP_RTYPE: begin
                case (funct)
                    FN_ADD:  begin dest = rd; wval = a + b; end
                    FN_SUB:  begin dest = rd; wval = a - b; end
                    FN_AND:  begin dest = rd; wval = a & b; end
                    FN_OR:   begin dest = rd; wval = a | b; end
                    FN_NOR:  begin dest = rd; wval = ~(a | b); end
                    FN_SLT:  begin dest = rd; wval = 32'($signed(a) < $signed(b)); end
                    FN_SLTU: begin dest = rd; wval = 32'(a < b); end
                    FN_SLL:  begin dest = rd; wval = b << shamt; end
                    FN_SRL:  begin dest = rd; wval = b >> shamt; end
                    FN_JR:   newpc = a[AW-1:0];
                    default: ;
                endcase
            end
            OP_ADDI:  begin dest = rt; wval = a + simm; end
            OP_SLTI:  begin dest = rt; wval = 32'($signed(a) < $signed(simm)); end
            OP_SLTIU: begin dest = rt; wval = 32'(a < simm); end
            OP_ANDI:  begin dest = rt; wval = a & zimm; end
            OP_ORI:   begin dest = rt; wval = a | zimm; end
            OP_XORI:  begin dest = rt; wval = a ^ zimm; end
            OP_BEQ:   if (a == b) newpc = AW'(pc4 + (simm << 2));
            OP_BNE:   if (a != b) newpc = AW'(pc4 + (simm << 2));
            OP_LBU, OP_LHU, OP_LW: is_mem = 1'b1;
            OP_SB:    begin is_mem = 1'b1; sbytes = 3'd1; end
            OP_SH:    begin is_mem = 1'b1; sbytes = 3'd2; end
            OP_SW:    begin is_mem = 1'b1; sbytes = 3'd4; end
            OP_J:     newpc = AW'((pc4 & 32'hF000_0000) | {4'd0, rd_word[25:0], 2'd0});
            OP_JAL: begin
                dest = 5'd31; wval = 32'(r_pc) + 32'd8;
                newpc = AW'((pc4 & 32'hF000_0000) | {4'd0, rd_word[25:0], 2'd0});
            end
            default: ;
        endcase
    end
    assign o_stat.needs_mem = is_mem;

    // load data from second memory read
    logic [31:0] ld_val;
    always_comb begin
        case (r_op)
            OP_LBU:  ld_val = {24'd0, rd_word[7:0]};
            OP_LHU:  ld_val = {16'd0, rd_word[15:0]};
            default: ld_val = rd_word;
        endcase
    end

    // store byte enables in byte order
    logic [3:0] st_en;
    assign st_en = (r_res.store_bytes == 3'd1) ? 4'b0001 :
                   (r_res.store_bytes == 3'd2) ? 4'b0011 : 4'b1111;

    // memory writes: input byte or store data
    logic          st_go;
    logic [AW-1:0] wb_addr [4];
    logic [7:0]    wb_data [4];
    logic          wb_en [4];
    assign st_go = i_cmd.mem && (r_res.store_bytes != 3'd0);
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            wb_en[l] = 1'b0; wb_addr[l] = '0; wb_data[l] = '0;
            if (i_cmd.wr_byte && i_mem_addr[1:0] == 2'(l)) begin
                wb_en[l] = 1'b1; wb_addr[l] = i_mem_addr[AW-1:0]; wb_data[l] = i_mem_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (st_go && st_en[k] && 2'(r_ea + AW'(k)) == 2'(l)) begin
                    wb_en[l] = 1'b1;
                    wb_addr[l] = r_ea + AW'(k);
                    wb_data[l] = r_b[8*k +: 8];
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (wb_en[0]) r_mem0[wb_addr[0][AW-1:2]] <= wb_data[0];
        if (wb_en[1]) r_mem1[wb_addr[1][AW-1:2]] <= wb_data[1];
        if (wb_en[2]) r_mem2[wb_addr[2][AW-1:2]] <= wb_data[2];
        if (wb_en[3]) r_mem3[wb_addr[3][AW-1:2]] <= wb_data[3];
    end

    // pc, register file, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            for (int i = 0; i < 32; i++) r_rf[i] <= '0;
            r_res <= '0;
        end else begin
            if (i_in_take) begin
                r_res <= t_result'{next_pc: r_pc, default: '0};
            end
            if (i_cmd.exec) begin
                r_pc <= newpc;
                r_res.next_pc <= newpc;
                r_res.store_bytes <= sbytes;
                r_res.store_addr <= sbytes != 3'd0 ? ea32[AW-1:0] : '0;
                r_ea <= ea32[AW-1:0];
                r_b <= b;
                r_op <= op;
                r_rt <= rt;
                if (dest != 5'd0) begin
                    if (!is_mem) r_rf[dest] <= wval;
                    r_res.reg_written <= 1'b1;
                    r_res.reg_index <= dest;
                    r_res.reg_value <= wval;
                end else if (is_mem && sbytes == 3'd0 && rt != 5'd0) begin
                    r_res.reg_written <= 1'b1;
                    r_res.reg_index <= rt;
                end
            end
            if (i_cmd.mem && r_res.store_bytes == 3'd0 && r_rt != 5'd0) begin
                r_rf[r_rt] <= ld_val;
                r_res.reg_value <= ld_val;
            end
        end
    end
    assign o_res = r_res;
endmodule

[tb/mips32_subset_single_cycle_core_test.sv]
// Self-checking testbench of the MIPS32 subset core: loads programs byte by byte,
// steps them and checks every result item against a behavioral model of the core.
// Depends on msc_pkg, msc_if and the core RTL.
`timescale 1ns / 1ps

class msc_scoreboard;
    logic [11:0] pc;
    logic [31:0] regs [32];
    logic [7:0]  mem [4096];
    msc_pkg::t_result pending [$];
    int errors;

    function void reset_core();
        pc = '0;
        for (int i = 0; i < 32; i++) regs[i] = '0;
    endfunction

    function logic [31:0] rd_le(logic [31:0] a, int n);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < n; k++) v |= 32'(mem[12'(a + k)]) << (8 * k);
        return v;
    endfunction

    // Compute the result of one accepted item and update the core state.
    function void note_item(logic req, logic [11:0] addr, logic [7:0] data);
        msc_pkg::t_result r;
        logic [31:0] inst, a, b, simm, zimm, ea, wval, pc4, npc;
        logic [5:0] op, fn;
        logic [4:0] rs, rt, rd, sh, dest;
        int sb;
        r = '0;
        if (!req) begin
            mem[addr] = data;
            r.next_pc = pc;
            pending.push_back(r);
            return;
        end
        inst = rd_le(32'(pc), 4);
        pc4 = 32'(12'(pc + 12'd4));
        npc = pc4;
        op = inst[31:26]; rs = inst[25:21]; rt = inst[20:16]; rd = inst[15:11];
        sh = inst[10:6]; fn = inst[5:0];
        zimm = {16'h0, inst[15:0]};
        simm = {{16{inst[15]}}, inst[15:0]};
        a = regs[rs]; b = regs[rt]; ea = a + simm;
        dest = '0; wval = '0; sb = 0;
        case (op)
            msc_pkg::OP_RTYPE: begin
                case (fn)
                    msc_pkg::FN_ADD: begin dest = rd; wval = a + b; end
                    msc_pkg::FN_SUB: begin dest = rd; wval = a - b; end
                    msc_pkg::FN_AND: begin dest = rd; wval = a & b; end
                    msc_pkg::FN_OR: begin dest = rd; wval = a | b; end
                    msc_pkg::FN_NOR: begin dest = rd; wval = ~(a | b); end
                    msc_pkg::FN_SLT: begin dest = rd; wval = 32'($signed(a) < $signed(b)); end
                    msc_pkg::FN_SLTU: begin dest = rd; wval = 32'(a < b); end
                    msc_pkg::FN_SLL: begin dest = rd; wval = b << sh; end
                    msc_pkg::FN_SRL: begin dest = rd; wval = b >> sh; end
                    msc_pkg::FN_JR: npc = 32'(a[11:0]);
                    default: ;
                endcase
            end
            msc_pkg::OP_ADDI: begin dest = rt; wval = a + simm; end
            msc_pkg::OP_SLTI: begin dest = rt; wval = 32'($signed(a) < $signed(simm)); end
            msc_pkg::OP_SLTIU: begin dest = rt; wval = 32'(a < simm); end
            msc_pkg::OP_ANDI: begin dest = rt; wval = a & zimm; end
            msc_pkg::OP_ORI: begin dest = rt; wval = a | zimm; end
            msc_pkg::OP_XORI: begin dest = rt; wval = a ^ zimm; end
            msc_pkg::OP_BEQ: if (a == b) npc = 32'(12'(pc4 + (simm << 2)));
            msc_pkg::OP_BNE: if (a != b) npc = 32'(12'(pc4 + (simm << 2)));
            msc_pkg::OP_LBU: begin dest = rt; wval = rd_le(ea, 1); end
            msc_pkg::OP_LHU: begin dest = rt; wval = rd_le(ea, 2); end
            msc_pkg::OP_LW: begin dest = rt; wval = rd_le(ea, 4); end
            msc_pkg::OP_SB, msc_pkg::OP_SH, msc_pkg::OP_SW: begin
                sb = (op == msc_pkg::OP_SB) ? 1 : (op == msc_pkg::OP_SH) ? 2 : 4;
                r.store_bytes = 3'(sb);
                r.store_addr = ea[11:0];
                for (int k = 0; k < sb; k++) mem[12'(ea + k)] = 8'(b >> (8 * k));
            end
            msc_pkg::OP_J, msc_pkg::OP_JAL: begin
                if (op == msc_pkg::OP_JAL) begin dest = 5'd31; wval = 32'(pc) + 32'd8; end
                npc = 32'(12'((pc4 & ~((32'd1 << 28) - 1)) | ({6'h0, inst[25:0]} << 2)));
            end
            default: ;
        endcase
        if (dest != 0) begin
            regs[dest] = wval;
            r.reg_written = 1'b1;
            r.reg_index = dest;
            r.reg_value = wval;
        end
        pc = npc[11:0];
        r.next_pc = pc;
        pending.push_back(r);
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_result(msc_pkg::t_result got);
        msc_pkg::t_result want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
    endfunction
endclass

module mips32_subset_single_cycle_core_test;
    import msc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    msc_in_if  in_ch ();
    msc_out_if out_ch ();

    mips32_subset_single_cycle_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    localparam int IDLE_LIMIT = 20000;

    msc_scoreboard core_model;
    logic       known [4096];
    int         steps_left;
    bit         out_stall_on;
    int         idle_cycles;

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.mem_addr = '0;
        in_ch.mem_byte = '0;
        out_ch.ready = 1'b0;
        core_model = new();
        core_model.reset_core();
        for (int i = 0; i < 4096; i++) known[i] = 1'b0;
    end

    // Mostly short gaps, now and then a long one, sometimes none for a while.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item and record it once it is accepted.
    task automatic send_item(logic req, logic [11:0] addr, logic [7:0] data);
        int g;
        g = out_stall_on ? gap_len() : 0;
        // drop valid over the gap and show junk on the payload
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            in_ch.req_type <= 1'($urandom);
            in_ch.mem_addr <= 12'($urandom);
            in_ch.mem_byte <= 8'($urandom);
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.mem_addr <= addr;
        in_ch.mem_byte <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        core_model.note_item(req, addr, data);
        if (!req) known[addr] = 1'b1;
    endtask

    task automatic put_word(logic [11:0] addr, logic [31:0] w);
        for (int k = 0; k < 4; k++) send_item(1'b0, 12'(addr + k), w[8*k +: 8]);
    endtask

    // Execute only when the word at pc is fully written.
    task automatic step_once();
        logic [11:0] p;
        p = core_model.pc;
        for (int k = 0; k < 4; k++)
            if (!known[12'(p + k)]) put_word(p, 32'h0000_0020);
        send_item(1'b1, '0, '0);
    endtask

    function automatic logic [31:0] r_op(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_op(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Random instruction; loads only hit written bytes, else become stores.
    function automatic logic [31:0] rand_inst();
        logic [5:0] ops [17];
        logic [5:0] fns [10];
        logic [5:0] op;
        logic [4:0] rs, rt;
        logic [31:0] ea;
        logic [15:0] imm;
        int n;
        ops = '{OP_RTYPE, OP_RTYPE, OP_RTYPE, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
                OP_XORI, OP_BEQ, OP_BNE, OP_LBU, OP_LHU, OP_LW, OP_SB, OP_SH, OP_SW};
        fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU, FN_SLL, FN_SRL,
                6'h3F};
        op = ops[$urandom_range(0, 16)];
        rs = 5'($urandom); rt = 5'($urandom);
        imm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed(8'($urandom)));
        if ($urandom_range(0, 60) == 0) return {OP_J, 26'($urandom)};
        if ($urandom_range(0, 60) == 0) return {OP_JAL, 26'($urandom)};
        if ($urandom_range(0, 80) == 0) return {6'h3F, 26'($urandom)};
        if (op == OP_RTYPE)
            return r_op(rs, rt, 5'($urandom), 5'($urandom), fns[$urandom_range(0, 9)]);
        if (op == OP_LBU || op == OP_LHU || op == OP_LW) begin
            n = (op == OP_LBU) ? 1 : (op == OP_LHU) ? 2 : 4;
            ea = core_model.regs[rs] + {{16{imm[15]}}, imm};
            for (int k = 0; k < n; k++)
                if (!known[12'(ea + k)]) op = OP_SW;
        end
        if (op == OP_SB || op == OP_SH || op == OP_SW) begin
            n = (op == OP_SB) ? 1 : (op == OP_SH) ? 2 : 4;
            ea = core_model.regs[rs] + {{16{imm[15]}}, imm};
            for (int k = 0; k < n; k++) known[12'(ea + k)] = 1'b1;
        end
        return i_op(op, rs, rt, imm);
    endfunction

    // Consume result items with random back-pressure.
    initial begin
        msc_pkg::t_result got;
        int g;
        @(posedge i_rst_n);
        forever begin
            g = out_stall_on ? gap_len() : 0;
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.next_pc = out_ch.next_pc;
            got.reg_written = out_ch.reg_written;
            got.reg_index = out_ch.reg_index;
            got.reg_value = out_ch.reg_value;
            got.store_bytes = out_ch.store_bytes;
            got.store_addr = out_ch.store_addr;
            core_model.check_result(got);
        end
    end

    // Count cycles with no accepted item on either side.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed program, then random programs, then drain.
    initial begin
        logic [31:0] prog [$];
        logic [11:0] base;
        idle_cycles = 0;
        out_stall_on = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prog = '{i_op(OP_ADDI, 5'd0, 5'd1, 16'hFFFF), i_op(OP_ORI, 5'd0, 5'd2, 16'hFFFF),
                 i_op(OP_XORI, 5'd1, 5'd3, 16'h8000), i_op(OP_ANDI, 5'd1, 5'd4, 16'hF0F0),
                 r_op(5'd1, 5'd2, 5'd5, 5'd0, FN_ADD), r_op(5'd2, 5'd1, 5'd6, 5'd0, FN_SUB),
                 r_op(5'd1, 5'd2, 5'd7, 5'd0, FN_SLT), r_op(5'd1, 5'd2, 5'd8, 5'd0, FN_SLTU),
                 r_op(5'd0, 5'd1, 5'd9, 5'd31, FN_SLL), r_op(5'd0, 5'd1, 5'd10, 5'd31, FN_SRL),
                 r_op(5'd1, 5'd2, 5'd11, 5'd0, FN_NOR), r_op(5'd1, 5'd2, 5'd0, 5'd0, FN_AND),
                 i_op(OP_SLTI, 5'd1, 5'd12, 16'h0000), i_op(OP_SLTIU, 5'd2, 5'd13, 16'hFFFF),
                 i_op(OP_SW, 5'd0, 5'd1, 16'h0FFE), i_op(OP_SH, 5'd0, 5'd2, 16'h0F00),
                 i_op(OP_SB, 5'd0, 5'd3, 16'h0F10), i_op(OP_LW, 5'd0, 5'd14, 16'h0FFE),
                 i_op(OP_LHU, 5'd0, 5'd15, 16'h0F00), i_op(OP_LBU, 5'd0, 5'd16, 16'h0F10),
                 r_op(5'd1, 5'd2, 5'd17, 5'd0, FN_OR), i_op(OP_BEQ, 5'd1, 5'd2, 16'h0001),
                 32'hFC00_0000, i_op(OP_BNE, 5'd1, 5'd0, 16'h0000),
                 {OP_JAL, 26'h3FF_FF00}};
        for (int i = 0; i < prog.size(); i++) put_word(12'(4 * i), prog[i]);
        foreach (prog[i]) step_once();
        // JR through r0 back to address zero
        put_word(core_model.pc, r_op(5'd0, 5'd0, 5'd0, 5'd0, FN_JR));
        step_once();

        out_stall_on = 1'b1;
        steps_left = 210;
        while (steps_left > 0) begin
            if ($urandom_range(0, 9) < 3) begin
                base = 12'($urandom);
                for (int k = 0; k < 4; k++) known[12'(base + k)] = 1'b1;
                put_word(base, 32'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    // Occasional noise write of one byte at a random address.
                    base = 12'($urandom);
                    send_item(1'b0, base, 8'($urandom));
                end
                put_word(core_model.pc, rand_inst());
                step_once();
                steps_left -= 1;
                if ($urandom_range(0, 30) == 0) out_stall_on = !out_stall_on;
            end
            if (steps_left % 100 == 0) begin
                // AND the known flags of the word at pc with one, which leaves them as they are.
                for (int k = 0; k < 4; k++) known[12'(core_model.pc + k)] &= 1'b1;
            end
        end
        in_ch.valid <= 1'b0;
        while (core_model.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (core_model.errors == 0 && core_model.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
